/* rtl/core/lc3b_pkg.sv */
package lc3b_pkg;

	localparam int unsigned MemWordsDefault = 4096;

	// Opcodes.
	localparam logic [3:0] OpBr   = 4'd0;
	localparam logic [3:0] OpAdd  = 4'd1;
	localparam logic [3:0] OpLdb  = 4'd2;
	localparam logic [3:0] OpStb  = 4'd3;
	localparam logic [3:0] OpJsr  = 4'd4;
	localparam logic [3:0] OpAnd  = 4'd5;
	localparam logic [3:0] OpLdw  = 4'd6;
	localparam logic [3:0] OpStw  = 4'd7;
	localparam logic [3:0] OpXor  = 4'd9;
	localparam logic [3:0] OpJmp  = 4'd12;
	localparam logic [3:0] OpShf  = 4'd13;
	localparam logic [3:0] OpLea  = 4'd14;
	localparam logic [3:0] OpTrap = 4'd15;

	localparam logic OperLoad = 1'b0;

	localparam logic [2:0] CcZero = 3'b010;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		if (v[15]) begin
			return 3'b100;
		end else if (v == 16'd0) begin
			return 3'b010;
		end
		return 3'b001;
	endfunction

endpackage

/* rtl/core/lc3b_ram.sv */
module lc3b_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/core/lc3b_instruction_executor.sv */
// LC-3b executor. A load transaction writes one word of program memory; a step
// transaction executes one instruction, or reports a halt when its PC is zero.
// Memory sits in one single-port RAM, so after reset a clearing pass over every
// word runs before the first item is taken. A load is written in the cycle it
// is accepted, which also registers its result. A step reads the instruction,
// captures it, then decodes and executes it, each in its own state; LDB, LDW
// and STB then need a data read in a further state before the register write
// or the byte merge; STW writes its word in the execute cycle. The single RAM
// port sets this order. Each item gives one result transaction on the master
// side, buffered in an output register, and the next item is taken only once
// that result is gone.
module lc3b_instruction_executor
	import lc3b_pkg::*;
#(
	parameter int unsigned MEM_WORDS = MemWordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] word_address, [27:12] word_data, pad zero to 32
	input  logic [31:0] s_tdata,
	// [0] operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] next_pc, [18:16] cond_nzp, [19] reg_written, [22:20] reg_index,
	// [38:23] reg_value, [39] mem_written, [55:40] mem_byte_address,
	// [71:56] mem_value, [72] mem_byte_only, pad zero to 80
	output logic [79:0] m_tdata,
	// [0] halted
	output logic        m_tuser
);

	localparam int unsigned AW = $clog2(MEM_WORDS);

	typedef enum logic [5:0] {
		StClear = 6'b000001,
		StIdle  = 6'b000010,
		StFetch = 6'b000100,
		StExec  = 6'b001000,
		StData  = 6'b010000,
		StOut   = 6'b100000
	} state_t;

	state_t      state_q;
	logic [AW:0] clr_q;
	logic [15:0] start_pc_q, pc_q, ir_q, addr_q;
	logic [2:0]  cc_q;
	logic        started_q;
	logic [15:0] rf_q [8];

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_wdata, ram_rdata;

	lc3b_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == StIdle) && !m_tvalid;

	// Decode of the held instruction.
	logic [3:0]  opc;
	logic [2:0]  dr, sr1;
	logic [15:0] ra, rb, pc2, off6, off9x2, off11x2, off6x2;
	assign opc     = ir_q[15:12];
	assign dr      = ir_q[11:9];
	assign sr1     = ir_q[8:6];
	assign ra      = rf_q[sr1];
	assign rb      = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : rf_q[ir_q[2:0]];
	assign pc2     = pc_q + 16'd2;
	assign off6    = {{10{ir_q[5]}}, ir_q[5:0]};
	assign off6x2  = {{9{ir_q[5]}}, ir_q[5:0], 1'b0};
	assign off9x2  = {{6{ir_q[8]}}, ir_q[8:0], 1'b0};
	assign off11x2 = {{4{ir_q[10]}}, ir_q[10:0], 1'b0};

	logic [15:0] shf;
	always_comb begin
		if (!ir_q[4]) begin
			shf = ra << ir_q[3:0];
		end else if (ir_q[5]) begin
			shf = 16'($signed(ra) >>> ir_q[3:0]);
		end else begin
			shf = ra >> ir_q[3:0];
		end
	end

	logic [15:0] ldb_addr, ldw_addr;
	assign ldb_addr = ra + off6;
	assign ldw_addr = ra + off6x2;

	// Memory port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pc_q[AW:1];
		ram_wdata = 16'd0;
		unique case (state_q)
			StClear: begin
				ram_we   = 1'b1;
				ram_addr = clr_q[AW-1:0];
			end
			StIdle: begin
				ram_we    = s_tvalid && s_tready && (s_tuser == OperLoad);
				ram_addr  = AW'(s_tdata[11:0]);
				ram_wdata = s_tdata[27:12];
			end
			StFetch: ram_addr = pc_q[AW:1];
			StExec: ram_addr = pc_q[AW:1];
			StOut: begin
				// The instruction is held now; start the data access or write the word.
				ram_addr = (opc == OpLdw || opc == OpStw) ? ldw_addr[AW:1] : ldb_addr[AW:1];
				if (opc == OpStw) begin
					ram_we    = 1'b1;
					ram_wdata = rf_q[dr];
				end
			end
			StData: begin
				ram_addr = addr_q[AW:1];
				ram_we   = (opc == OpStb);
				ram_wdata = addr_q[0] ? {rf_q[dr][7:0], ram_rdata[7:0]}
					: {ram_rdata[15:8], rf_q[dr][7:0]};
			end
			default: ;
		endcase
	end

	// Instruction result.
	logic [15:0] res, npc;
	logic        wr, setcc, needs_data;
	always_comb begin
		res = 16'd0; wr = 1'b0; setcc = 1'b0; npc = pc2; needs_data = 1'b0;
		unique case (opc) inside
			OpAdd: begin res = ra + rb; wr = 1'b1; setcc = 1'b1; end
			OpAnd: begin res = ra & rb; wr = 1'b1; setcc = 1'b1; end
			OpXor: begin res = ra ^ rb; wr = 1'b1; setcc = 1'b1; end
			OpBr: begin
				if ((dr & cc_q) != 3'd0) npc = pc2 + off9x2;
			end
			OpJmp: npc = ra;
			OpJsr: begin
				res = pc2; wr = 1'b1;
				npc = ir_q[11] ? pc2 + off11x2 : ra;
			end
			OpLea: begin res = pc2 + off9x2; wr = 1'b1; end
			OpShf: begin res = shf; wr = 1'b1; setcc = 1'b1; end
			OpLdb, OpLdw, OpStb: needs_data = 1'b1;
			OpTrap: npc = 16'd0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StClear;
			clr_q      <= '0;
			start_pc_q <= 16'd0;
			pc_q       <= 16'd0;
			ir_q       <= 16'd0;
			addr_q     <= 16'd0;
			cc_q       <= CcZero;
			started_q  <= 1'b0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= 1'b0;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
		end else begin
			if (cfg_valid) start_pc_q <= cfg_data;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				StClear: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW + 1)'(MEM_WORDS - 1)) state_q <= StIdle;
				end
				StIdle: begin
					if (s_tvalid && s_tready) begin
						if (s_tuser == OperLoad) begin
							m_tdata  <= {61'd0, cc_q, pc_q};
							m_tuser  <= 1'b0;
							m_tvalid <= 1'b1;
						end else begin
							logic [15:0] p;
							p = started_q ? pc_q : start_pc_q;
							started_q <= 1'b1;
							pc_q      <= p;
							if (p == 16'd0) begin
								m_tdata  <= {61'd0, cc_q, 16'd0};
								m_tuser  <= 1'b1;
								m_tvalid <= 1'b1;
							end else begin
								m_tuser <= 1'b0;
								state_q <= StFetch;
							end
						end
					end
				end
				StFetch: state_q <= StExec;
				StExec: begin
					ir_q    <= ram_rdata;
					state_q <= StOut;
				end
				StOut: begin
					// Instruction is in ir_q; settle simple ops or start data access.
					if (needs_data) begin
						addr_q  <= (opc == OpLdw) ? ldw_addr : ldb_addr;
						state_q <= StData;
					end else begin
						logic [2:0] wd, cc_n;
						logic       st;
						wd   = (opc == OpJsr) ? 3'd7 : dr;
						cc_n = setcc ? cc_of(res) : cc_q;
						st   = (opc == OpStw);
						if (wr) rf_q[wd] <= res;
						cc_q     <= cc_n;
						pc_q     <= npc;
						m_tdata  <= {7'd0, 1'b0, st ? rf_q[dr] : 16'd0,
							st ? {ldw_addr[15:1], 1'b0} : 16'd0, st,
							wr ? res : 16'd0, wr ? wd : 3'd0, wr, cc_n, npc};
						m_tvalid <= 1'b1;
						state_q  <= StIdle;
					end
				end
				StData: begin
					logic [15:0] v;
					v = ram_rdata;
					if (opc == OpLdb) v = addr_q[0] ? {{8{v[15]}}, v[15:8]} : {{8{v[7]}}, v[7:0]};
					if (opc == OpStb) begin
						m_tdata <= {7'd0, 1'b1, 8'd0, rf_q[dr][7:0], addr_q, 1'b1,
							16'd0, 3'd0, 1'b0, cc_q, pc2};
					end else begin
						rf_q[dr] <= v;
						cc_q     <= cc_of(v);
						m_tdata  <= {7'd0, 1'b0, 16'd0, 16'd0, 1'b0, v, dr, 1'b1,
							cc_of(v), pc2};
					end
					pc_q     <= pc2;
					m_tvalid <= 1'b1;
					state_q  <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule
